// ===== src/kmv_pkg.sv =====
// Package for the Kronecker matrix-vector product block.
// Holds shared constants, command codes and register indexes; no dependencies.
package kmv_pkg;

  localparam int unsigned MAX_DIM_DEF = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned ACC_W       = 104;

  // B taken as 1.0 in Q16.16
  localparam logic signed [DATA_W-1:0] UNITY = 32'sh0001_0000;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_LOAD_V  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS     = 3'd0,
    REG_A_COLS     = 3'd1,
    REG_B_ROWS     = 3'd2,
    REG_B_COLS     = 3'd3,
    REG_IDENTITY_B = 3'd4
  } reg_idx_e;

endpackage

// ===== src/kmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module kmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/kronecker_matrix_vector_product_top.sv =====
// Kronecker matrix-vector product, vec(B * V * A^T), Q16.16 with saturation.
// Loads: one transfer per cycle while idle, stored the same cycle, no result.
// Compute: each triple product steps through RAM read, V*A multiply, two partial
// multiplies by B and accumulate, and each result through an emit step that waits
// for the output register; kn = b_cols, or 1 with identity_b. One item in flight at a time.
// Reset clears control and config registers (8,8,8,8,0); stores are undefined.
module kronecker_matrix_vector_product_top #(
  parameter int unsigned MAX_DIM = kmv_pkg::MAX_DIM_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [kmv_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [kmv_pkg::DIM_W-1:0]           cfg_wdata_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [2:0]                          row_i,
  input  logic [2:0]                          col_i,
  input  logic signed [kmv_pkg::DATA_W-1:0]   value_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [kmv_pkg::POS_W-1:0]           position_o,
  output logic signed [kmv_pkg::DATA_W-1:0]   result_value_o,
  output logic                                last_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW    = kmv_pkg::DIM_W;
  localparam int unsigned XW    = kmv_pkg::DATA_W;
  localparam int unsigned AccW  = kmv_pkg::ACC_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_MLO  = 7'b0001000,
    ST_MHI  = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [DW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic          identity_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q     <= DW'(8);
      a_cols_q     <= DW'(8);
      b_rows_q     <= DW'(8);
      b_cols_q     <= DW'(8);
      identity_b_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        kmv_pkg::REG_A_ROWS:     a_rows_q     <= cfg_wdata_i;
        kmv_pkg::REG_A_COLS:     a_cols_q     <= cfg_wdata_i;
        kmv_pkg::REG_B_ROWS:     b_rows_q     <= cfg_wdata_i;
        kmv_pkg::REG_B_COLS:     b_cols_q     <= cfg_wdata_i;
        kmv_pkg::REG_IDENTITY_B: identity_b_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // clamp a dimension register into 1..MAX_DIM
  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] r);
    logic [DW-1:0] res;
    res = r;
    if (r == '0) res = DW'(1);
    else if (32'(r) > MAX_DIM) res = DW'(MAX_DIM);
    return res;
  endfunction

  logic [DW-1:0] ar, ac, br, bc, orows, kn;
  assign ar    = clamp_dim(a_rows_q);
  assign ac    = clamp_dim(a_cols_q);
  assign br    = clamp_dim(b_rows_q);
  assign bc    = clamp_dim(b_cols_q);
  assign orows = identity_b_q ? bc : br;
  assign kn    = identity_b_q ? DW'(1) : bc;

  // loop counters: j over A rows, i over result rows, l over A cols, k over B cols
  logic [DW-1:0] j_q, j_d, i_q, i_d, l_q, l_d, k_q, k_d;
  logic [kmv_pkg::POS_W-1:0] pos_q, pos_d;

  // load path: write the addressed store while idle
  logic          in_xfer, load_ok;
  logic [AW-1:0] wr_addr;
  kmv_pkg::cmd_e cmd;

  assign cmd        = kmv_pkg::cmd_e'(command_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_ok    = in_xfer && (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
  assign wr_addr    = AW'(32'(row_i) * MAX_DIM + 32'(col_i));

  // read addresses follow the counters; data shows up in the next cycle
  logic [AW-1:0] a_raddr, b_raddr, v_raddr;
  logic [DW-1:0] v_row;
  assign v_row   = identity_b_q ? i_q : k_q;
  assign a_raddr = AW'(32'(j_q) * MAX_DIM + 32'(l_q));
  assign b_raddr = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
  assign v_raddr = AW'(32'(v_row) * MAX_DIM + 32'(l_q));

  logic [XW-1:0] a_rdata, b_rdata, v_rdata;

  kmv_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_a_ram (
    .clk_i, .we_i(load_ok && cmd == kmv_pkg::CMD_LOAD_A), .waddr_i(wr_addr),
    .wdata_i(value_i), .raddr_i(a_raddr), .rdata_o(a_rdata)
  );
  kmv_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_b_ram (
    .clk_i, .we_i(load_ok && cmd == kmv_pkg::CMD_LOAD_B), .waddr_i(wr_addr),
    .wdata_i(value_i), .raddr_i(b_raddr), .rdata_o(b_rdata)
  );
  kmv_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_v_ram (
    .clk_i, .we_i(load_ok && cmd == kmv_pkg::CMD_LOAD_V), .waddr_i(wr_addr),
    .wdata_i(value_i), .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  // datapath: p = V*A, then p*B split into low (unsigned) and high (signed) halves
  logic signed [2*XW-1:0]   p_q;
  logic signed [2*XW:0]     plo_q;
  logic signed [2*XW-1:0]   phi_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [XW-1:0]     b_sel;
  assign b_sel = identity_b_q ? kmv_pkg::UNITY : $signed(b_rdata);

  // emit_go is driven with the output stage below
  logic                      emit_go;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL: p_q   <= $signed(v_rdata) * $signed(a_rdata);
      ST_MLO: plo_q <= $signed({1'b0, p_q[XW-1:0]}) * b_sel;
      ST_MHI: phi_q <= $signed(p_q[2*XW-1:XW]) * b_sel;
      default: ;
    endcase
    // hold the sum while a finished element waits for the output register
    if (state_q == ST_ACC) begin
      acc_q <= acc_q + {{(AccW-3*XW){phi_q[2*XW-1]}}, phi_q, {XW{1'b0}}}
                     + {{(AccW-2*XW-1){plo_q[2*XW]}}, plo_q};
    end else if (state_q == ST_IDLE || emit_go) begin
      acc_q <= '0;
    end
  end

  // floor shift by 32 and saturate
  logic signed [XW-1:0] sat_val;
  logic                 fits;
  assign fits = (acc_q[AccW-1:2*XW-1] == '0) || (acc_q[AccW-1:2*XW-1] == '1);
  always_comb begin
    if (fits) sat_val = acc_q[2*XW-1:XW];
    else if (acc_q[AccW-1]) sat_val = {1'b1, {(XW-1){1'b0}}};
    else sat_val = {1'b0, {(XW-1){1'b1}}};
  end

  // output register parts the sequencer from the consumer
  logic                      ov_q;
  logic [kmv_pkg::POS_W-1:0] opos_q;
  logic signed [XW-1:0]      oval_q;
  logic                      olast_q;
  logic                      row_end, col_end;

  assign row_end = (i_q == orows - DW'(1));
  assign col_end = (j_q == ar - DW'(1));
  assign emit_go = (state_q == ST_EMIT) && (!ov_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit_go) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      opos_q  <= pos_q;
      oval_q  <= sat_val;
      olast_q <= row_end && col_end;
    end
  end

  assign out_valid_o    = ov_q;
  assign position_o     = opos_q;
  assign result_value_o = oval_q;
  assign last_o         = olast_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    i_d     = i_q;
    l_d     = l_q;
    k_d     = k_q;
    pos_d   = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && cmd == kmv_pkg::CMD_COMPUTE) begin
          j_d     = '0;
          i_d     = '0;
          l_d     = '0;
          k_d     = '0;
          pos_d   = '0;
          state_d = ST_RD;
        end
      end
      ST_RD:  state_d = ST_MUL;
      ST_MUL: state_d = ST_MLO;
      ST_MLO: state_d = ST_MHI;
      ST_MHI: state_d = ST_ACC;
      ST_ACC: begin
        // advance k inside l; finish the element after the last term
        if (k_q == kn - DW'(1)) begin
          k_d = '0;
          if (l_q == ac - DW'(1)) begin
            l_d     = '0;
            state_d = ST_EMIT;
          end else begin
            l_d     = l_q + DW'(1);
            state_d = ST_RD;
          end
        end else begin
          k_d     = k_q + DW'(1);
          state_d = ST_RD;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          pos_d = pos_q + kmv_pkg::POS_W'(1);
          if (row_end) begin
            i_d = '0;
            if (col_end) begin
              state_d = ST_IDLE;
            end else begin
              j_d     = j_q + DW'(1);
              state_d = ST_RD;
            end
          end else begin
            i_d     = i_q + DW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      i_q     <= '0;
      l_q     <= '0;
      k_q     <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      i_q     <= i_d;
      l_q     <= l_d;
      k_q     <= k_d;
      pos_q   <= pos_d;
    end
  end

endmodule
